// ===== design/ubsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ubsd_pkg
// Shared types and codes of the Unicode byte stream decoder.
// ----------------------------------------------------------------------------
package ubsd_pkg;

	typedef enum logic [2:0] {
		ENC_ASCII    = 3'd0,
		ENC_UTF8     = 3'd1,
		ENC_UTF16_LE = 3'd2,
		ENC_UTF16_BE = 3'd3,
		ENC_UTF32_LE = 3'd4,
		ENC_UTF32_BE = 3'd5
	} encoding_t;

	typedef enum logic [1:0] {
		STATUS_CODE_POINT = 2'd0,
		STATUS_ERROR      = 2'd1,
		STATUS_EMPTY_END  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_CP   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [31:0] BYTE_ORDER_MARK = 32'h0000_FEFF;
	localparam logic [31:0] SUPPLEMENTARY_BASE = 32'h0001_0000;
	localparam logic [5:0]  HIGH_SURROGATE_TAG = 6'b110110;
	localparam logic [5:0]  LOW_SURROGATE_TAG  = 6'b110111;

	typedef struct packed {
		logic [31:0] partial_unit;
		logic [1:0]  bytes_seen;
		logic [2:0]  bytes_expected;
		logic [9:0]  high_half;
		logic        have_high_half;
		logic        at_string_start;
		logic        dropping_rest;
	} dec_state_t;

	localparam dec_state_t STATE_CLEAR = '{
		partial_unit:    32'd0,
		bytes_seen:      2'd0,
		bytes_expected:  3'd0,
		high_half:       10'd0,
		have_high_half:  1'b0,
		at_string_start: 1'b1,
		dropping_rest:   1'b0
	};

	typedef struct packed {
		logic [31:0] code_point;
		status_t     status;
		logic        string_end;
	} result_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       string_start;
		logic       string_last;
	} in_item_t;

endpackage

// ===== design/unicode_byte_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// unicode_byte_stream_decoder
// Decodes a byte stream in ASCII, UTF-8, UTF-16 or UTF-32 to code points.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while its results are taken, and gives at
// most one result per byte. A byte taken is held in the input register, and
// its result is loaded into the result register once that register can take
// it, and the consumer takes it from there. The decoder state is updated once
// per byte, which sets the sustained rate of one byte per clock while results
// are taken. A result waiting in the output register holds the byte in the
// input register, so the input stalls until the waiting result is taken. The
// encoding register should be written only while no byte is in flight.
module unicode_byte_stream_decoder
	import ubsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        string_start,
	input  logic        string_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] code_point,
	output logic [1:0]  status,
	output logic        string_end
);

	encoding_t encoding_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      can_take;
	logic      res_valid;
	result_t   res;
	result_t   out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoding_q <= ENC_UTF8;
		end else if (cfg_we) begin
			encoding_q <= encoding_t'(cfg_data);
		end
	end

	assign advance  = valid_s1 && can_take;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{byte_value: byte_value, string_start: string_start,
				string_last: string_last};
		end
	end

	ubsd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.encoding  (encoding_q),
		.advance   (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ubsd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign code_point = out_res.code_point;
	assign status     = out_res.status;
	assign string_end = out_res.string_end;

endmodule

// ===== design/ubsd_decode.sv =====
// ----------------------------------------------------------------------------
// ubsd_decode
// Per-string decoder state and the combinational decode of one byte.
// ----------------------------------------------------------------------------
module ubsd_decode
	import ubsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  encoding_t encoding,
	input  logic      advance,
	input  in_item_t  item,
	output logic      res_valid,
	output result_t   res
);

	dec_state_t state_q;
	dec_state_t state_d;

	always_comb begin
		dec_state_t e;
		dec_state_t n;
		kind_t       kind;
		logic [31:0] cp;
		logic [15:0] u;
		logic [1:0]  seen_inc;
		logic [2:0]  seen_plus;
		logic [7:0]  b;
		b = item.byte_value;
		e = item.string_start ? STATE_CLEAR : state_q;
		n = e;
		kind = KIND_NONE;
		cp = 32'd0;
		u = 16'd0;
		seen_inc = 2'd0;
		seen_plus = 3'd0;
		res_valid = 1'b0;
		res = '{code_point: 32'd0, status: STATUS_CODE_POINT, string_end: 1'b0};

		if (e.dropping_rest) begin
			if (item.string_last) begin
				n = STATE_CLEAR;
			end
		end else begin
			case (encoding)
				ENC_ASCII: begin
					cp = {24'd0, b};
					kind = KIND_CP;
				end
				ENC_UTF8: begin
					if (e.bytes_expected == 3'd0) begin
						n.bytes_seen = 2'd0;
						if (!b[7]) begin
							cp = {24'd0, b};
							kind = KIND_CP;
						end else if (b[7:5] == 3'b110) begin
							n.partial_unit = {27'd0, b[4:0]};
							n.bytes_expected = 3'd2;
						end else if (b[7:4] == 4'b1110) begin
							n.partial_unit = {28'd0, b[3:0]};
							n.bytes_expected = 3'd3;
						end else if (b[7:3] == 5'b11110) begin
							n.partial_unit = {29'd0, b[2:0]};
							n.bytes_expected = 3'd4;
						end else begin
							kind = KIND_ERR;
						end
					end else begin
						n.partial_unit = {e.partial_unit[25:0], b[5:0]};
						seen_inc = e.bytes_seen + 2'd1;
						n.bytes_seen = seen_inc;
						seen_plus = {1'b0, seen_inc} + 3'd1;
						if (seen_plus >= e.bytes_expected) begin
							cp = n.partial_unit;
							n.partial_unit = 32'd0;
							n.bytes_seen = 2'd0;
							n.bytes_expected = 3'd0;
							kind = KIND_CP;
						end
					end
				end
				ENC_UTF16_LE, ENC_UTF16_BE: begin
					if (e.bytes_seen == 2'd0) begin
						n.partial_unit = {24'd0, b};
						n.bytes_seen = 2'd1;
					end else begin
						u = (encoding == ENC_UTF16_LE) ? {b, e.partial_unit[7:0]}
							: {e.partial_unit[7:0], b};
						n.partial_unit = 32'd0;
						n.bytes_seen = 2'd0;
						if (e.have_high_half) begin
							n.have_high_half = 1'b0;
							if (u[15:10] == LOW_SURROGATE_TAG) begin
								cp = SUPPLEMENTARY_BASE + {12'd0, e.high_half, u[9:0]};
								kind = KIND_CP;
							end else begin
								kind = KIND_ERR;
							end
						end else if (u[15:10] == HIGH_SURROGATE_TAG) begin
							n.high_half = u[9:0];
							n.have_high_half = 1'b1;
						end else if (u[15:10] == LOW_SURROGATE_TAG) begin
							kind = KIND_ERR;
						end else begin
							cp = {16'd0, u};
							kind = KIND_CP;
						end
					end
				end
				ENC_UTF32_LE, ENC_UTF32_BE: begin
					if (encoding == ENC_UTF32_LE) begin
						n.partial_unit = e.partial_unit
							| ({24'd0, b} << {e.bytes_seen, 3'b000});
					end else begin
						n.partial_unit = {e.partial_unit[23:0], b};
					end
					if (e.bytes_seen == 2'd3) begin
						cp = n.partial_unit;
						n.partial_unit = 32'd0;
						n.bytes_seen = 2'd0;
						kind = KIND_CP;
					end else begin
						n.bytes_seen = e.bytes_seen + 2'd1;
					end
				end
				default: begin
					kind = KIND_NONE;
				end
			endcase

			if (kind == KIND_CP && cp == BYTE_ORDER_MARK) begin
				kind = e.at_string_start ? KIND_NONE : KIND_ERR;
			end
			if (kind == KIND_NONE && item.string_last && (n.bytes_seen != 2'd0
				|| n.bytes_expected != 3'd0 || n.have_high_half)) begin
				kind = KIND_ERR;
			end

			case (kind)
				KIND_ERR: begin
					res_valid = 1'b1;
					res = '{code_point: 32'd0, status: STATUS_ERROR, string_end: 1'b1};
					n = STATE_CLEAR;
					n.dropping_rest = !item.string_last;
				end
				KIND_CP: begin
					res_valid = 1'b1;
					res = '{code_point: cp, status: STATUS_CODE_POINT,
						string_end: item.string_last};
					n.at_string_start = 1'b0;
					if (item.string_last) begin
						n = STATE_CLEAR;
					end
				end
				default: begin
					if (item.string_last) begin
						res_valid = 1'b1;
						res = '{code_point: 32'd0, status: STATUS_EMPTY_END,
							string_end: 1'b1};
						n = STATE_CLEAR;
					end
				end
			endcase
		end
		state_d = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/ubsd_out_reg.sv =====
// ----------------------------------------------------------------------------
// ubsd_out_reg
// Result register that holds one decoded word until the consumer takes it.
// ----------------------------------------------------------------------------
module ubsd_out_reg
	import ubsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    can_take,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_s2;
	result_t res_s2;

	assign can_take  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_take) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			res_s2 <= res;
		end
	end

endmodule
